// ===== rtl/ssd_pkg.sv =====
package ssd_pkg;

  localparam int unsigned SegW     = 7;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned NumDigit = 3;
  localparam int unsigned PosW     = 2;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_FAULT_CODE = 1'b0;

  localparam logic [SegW-1:0] SEG_ALL_OFF = 7'h7F;
  localparam logic [SegW-1:0] SEG_E       = 7'h12;
  localparam logic [SegW-1:0] SEG_R       = 7'h76;
  localparam logic [SegW-1:0] SEG_ONE     = 7'h6D;

  localparam logic [13:0] SAT_MAX = 14'd9999;

  typedef enum logic {
    OP_NUMBER = 1'b0,
    OP_ERROR  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               opcode;
    logic [ValueW-1:0] value;
    logic              value_new;
    logic [CodeW-1:0]  error_code;
  } ssd_item_t;

  typedef struct packed {
    logic [SegW-1:0]     segments_n;
    logic [NumDigit-1:0] digit_enable_n;
    logic                value_taken;
  } ssd_result_t;

  // active-low segment pattern of a decimal digit
  function automatic logic [SegW-1:0] digit_glyph(input logic [DigitW-1:0] d);
    logic [SegW-1:0] seg;
    case (d)
      4'd0:    seg = 7'h01;
      4'd1:    seg = 7'h6D;
      4'd2:    seg = 7'h22;
      4'd3:    seg = 7'h28;
      4'd4:    seg = 7'h4C;
      4'd5:    seg = 7'h18;
      4'd6:    seg = 7'h10;
      4'd7:    seg = 7'h2D;
      4'd8:    seg = 7'h00;
      4'd9:    seg = 7'h08;
      default: seg = SEG_ALL_OFF;
    endcase
    return seg;
  endfunction

  function automatic logic [NumDigit-1:0] enable_for(input logic [PosW-1:0] pos);
    logic [NumDigit-1:0] en;
    case (pos)
      2'd1:    en = 3'b101;
      2'd2:    en = 3'b011;
      default: en = 3'b110;
    endcase
    return en;
  endfunction

endpackage

// ===== rtl/ssd_digit_split.sv =====
module ssd_digit_split (
  input  logic [ssd_pkg::ValueW-1:0] value,
  output logic [ssd_pkg::DigitW-1:0] thousands,
  output logic [ssd_pkg::DigitW-1:0] hundreds,
  output logic [ssd_pkg::DigitW-1:0] tens
);
  import ssd_pkg::*;

  logic [13:0] sat;
  logic [26:0] th_prod;
  logic [13:0] th_rem;
  logic [9:0]  rem_h;
  logic [15:0] h_prod;
  logic [9:0]  h_rem;
  logic [6:0]  rem_t;
  logic [14:0] t_prod;

  // divide by constants with reciprocal multiplies, exact for 0..9999
  always_comb begin
    sat       = (value > ValueW'(SAT_MAX)) ? SAT_MAX : value[13:0];
    th_prod   = 27'(sat) * 27'd8389;
    thousands = th_prod[26:23];
    th_rem    = sat - 14'(thousands) * 14'd1000;
    rem_h     = th_rem[9:0];
    h_prod    = 16'(rem_h) * 16'd41;
    hundreds  = h_prod[15:12];
    h_rem     = rem_h - 10'(hundreds) * 10'd100;
    rem_t     = h_rem[6:0];
    t_prod    = 15'(rem_t) * 15'd205;
    tens      = t_prod[14:11];
  end

endmodule

// ===== rtl/ssd_scan_core.sv =====
module ssd_scan_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  ssd_pkg::ssd_item_t        item,
  input  logic [ssd_pkg::CodeW-1:0] fault_code,
  output ssd_pkg::ssd_result_t      result
);
  import ssd_pkg::*;

  logic [PosW-1:0]   num_pos;
  logic [PosW-1:0]   num_pos_next;
  logic [DigitW-1:0] digits [NumDigit];
  logic [PosW-1:0]   err_pos;
  logic [PosW-1:0]   err_pos_next;
  logic              err_latched;
  logic              err_latched_next;
  logic [CodeW-1:0]  err_code;
  logic [CodeW-1:0]  err_code_next;

  logic [DigitW-1:0] split_th;
  logic [DigitW-1:0] split_h;
  logic [DigitW-1:0] split_t;
  logic [PosW-1:0]   pos;
  logic              latch;
  logic [DigitW-1:0] shown;

  ssd_digit_split u_split (
    .value     (item.value),
    .thousands (split_th),
    .hundreds  (split_h),
    .tens      (split_t)
  );

  always_comb begin
    num_pos_next     = num_pos;
    err_pos_next     = err_pos;
    err_latched_next = err_latched;
    err_code_next    = err_code;
    latch            = 1'b0;
    shown            = '0;
    result           = '0;
    if (item.opcode == OP_NUMBER) begin
      pos   = (num_pos == 2'd3) ? 2'd0 : num_pos;
      latch = item.value_new && (pos == 2'd0);
      case (pos)
        2'd1:    shown = digits[1];
        2'd2:    shown = digits[2];
        default: shown = latch ? split_th : digits[0];
      endcase
      result.segments_n  = digit_glyph(shown);
      result.value_taken = latch;
      num_pos_next       = (pos == 2'd2) ? 2'd0 : pos + 2'd1;
    end else begin
      pos = (err_pos == 2'd3) ? 2'd0 : err_pos;
      if (!err_latched) begin
        err_latched_next = 1'b1;
        err_code_next    = item.error_code;
      end
      case (pos)
        2'd0:    result.segments_n = SEG_E;
        2'd1:    result.segments_n = SEG_R;
        default: result.segments_n = (err_code_next == fault_code) ? SEG_ONE : SEG_ALL_OFF;
      endcase
      if (pos == 2'd2) begin
        err_pos_next     = 2'd0;
        err_latched_next = 1'b0;
      end else begin
        err_pos_next = pos + 2'd1;
      end
    end
    result.digit_enable_n = enable_for(pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_pos     <= '0;
      err_pos     <= '0;
      err_latched <= 1'b0;
      err_code    <= '0;
      digits[0]   <= '0;
      digits[1]   <= '0;
      digits[2]   <= '0;
    end else if (advance) begin
      num_pos     <= num_pos_next;
      err_pos     <= err_pos_next;
      err_latched <= err_latched_next;
      err_code    <= err_code_next;
      if (latch) begin
        digits[0] <= split_th;
        digits[1] <= split_h;
        digits[2] <= split_t;
      end
    end
  end

  // scan wraps after the third digit
  assert property (@(posedge clk) disable iff (rst)
    advance && item.opcode == OP_NUMBER && num_pos == 2'd2 |=> num_pos == 2'd0)
    else $error("number scan did not wrap");

  // a latch only happens while the first digit is lit
  assert property (@(posedge clk) disable iff (rst)
    result.value_taken |-> result.digit_enable_n == 3'b110 && item.opcode == OP_NUMBER)
    else $error("value taken off the first digit");

  // error code stays latched within a scan
  assert property (@(posedge clk) disable iff (rst)
    advance && item.opcode == OP_ERROR && err_pos != 2'd2 |=> err_latched)
    else $error("error latch lost mid scan");

  assert property (@(posedge clk) disable iff (rst)
    num_pos != 2'd3 && err_pos != 2'd3)
    else $error("scan position out of range");

  // digits change only on a latch
  assert property (@(posedge clk) disable iff (rst)
    !(advance && latch) |=> $stable(digits[1]) && $stable(digits[2]))
    else $error("digits changed without a latch");

endmodule

// ===== rtl/seven_segment_scan_driver.sv =====
// Scan driver for a three-digit common-anode seven-segment display. Each input word is one
// refresh tick and gives exactly one output word: the active-low segment pattern and the
// active-low digit enable of the digit lit for that tick. Number ticks (tuser = 0) show the
// thousands, hundreds and tens of the latched value, saturated to 9999; a new value is taken
// only on the first digit when value_new is set, and value_taken reports it. Error ticks
// (tuser = 1) show E, r and a one glyph when the code latched at the start of the scan equals
// the fault_code register (APB address 0). Number and error modes keep separate scan
// positions. One word is accepted per cycle while the output is not stalled; each word is
// held in the input register while the scan logic and the digit split feed the result
// register. A stalled output holds the input register.
module seven_segment_scan_driver (
  input  logic                         clk,
  input  logic                         rst,
  // apb configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssd_pkg::ApbAddrW-1:0] paddr,
  input  logic [ssd_pkg::ApbDataW-1:0] pwdata,
  output logic [ssd_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,  // value[15:0], value_new[16], error_code[24:17]
  input  logic                         s_tuser,  // opcode
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [15:0]                  m_tdata   // segments_n[6:0], digit_enable_n[9:7],
                                                 // value_taken[10]
);
  import ssd_pkg::*;

  logic [CodeW-1:0] fault_code;
  logic             in_valid;
  ssd_item_t        in_item;
  logic             out_valid;
  ssd_result_t      out_item;
  ssd_result_t      core_result;
  logic             advance;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FAULT_CODE) ? ApbDataW'(fault_code) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_code <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FAULT_CODE) begin
      fault_code <= pwdata[CodeW-1:0];
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode     <= op_t'(s_tuser);
      in_item.value      <= s_tdata[15:0];
      in_item.value_new  <= s_tdata[16];
      in_item.error_code <= s_tdata[24:17];
    end
  end

  ssd_scan_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (in_item),
    .fault_code (fault_code),
    .result     (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_item.value_taken, out_item.digit_enable_n, out_item.segments_n};

endmodule
